[hw/rtl/gsgp_pkg.sv]
// Shared constants for the greedy streaming graph partitioner.
// Field widths, register codes and reset values; no dependencies.
package gsgp_pkg;

   // Vertex table depth default and partition count.
   localparam int MAX_VERTICES_DEF = 65536;
   localparam int MAX_PARTS        = 16;
   localparam int PART_W           = $clog2(MAX_PARTS);

   // Request and result field widths.
   localparam int VERTEX_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int LABEL_W  = 5;
   localparam int SIZE_W   = 17;

   // Datapath widths: saturating edge sum, size penalty and exact score.
   localparam int SUM_W    = 48;
   localparam int SUM_LO_W = SUM_W / 2;
   localparam int SUM_HI_W = SUM_W - SUM_LO_W;
   localparam int CAP_W    = 32;
   localparam int PEN_W    = CAP_W + 1;
   localparam int LO_P_W   = SUM_LO_W + 1 + PEN_W;
   localparam int HI_P_W   = SUM_HI_W + PEN_W;
   localparam int SCORE_W  = SUM_W + PEN_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PARTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 2'd1;

   // Register reset values.
   localparam logic [LABEL_W-1:0] NUM_PARTS_RST = 5'd2;
   localparam logic [CAP_W-1:0]   CAPACITY_RST  = 32'd4096;

   // Request kinds.
   localparam logic KIND_EDGE   = 1'b0;
   localparam logic KIND_ASSIGN = 1'b1;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [SIZE_W-1:0]       size_type;

endpackage

[hw/rtl/gsgp_if.sv]
// Channel interfaces of the graph partitioner: request, result and register write.
// Depends on gsgp_pkg for field widths.
interface gsgp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  kind;
   logic [gsgp_pkg::VERTEX_W-1:0]         vertex_id;
   logic [gsgp_pkg::VERTEX_W-1:0]         dest_vertex;
   logic signed [gsgp_pkg::WEIGHT_W-1:0]  edge_weight;

   modport source (output valid, kind, vertex_id, dest_vertex, edge_weight, input ready);
   modport sink   (input valid, kind, vertex_id, dest_vertex, edge_weight, output ready);
endinterface

interface gsgp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gsgp_pkg::VERTEX_W-1:0]  out_vertex;
   logic [gsgp_pkg::LABEL_W-1:0]   out_partition;
   logic [gsgp_pkg::SIZE_W-1:0]    out_size;

   modport source (output valid, out_vertex, out_partition, out_size, input ready);
   modport sink   (input valid, out_vertex, out_partition, out_size, output ready);
endinterface

interface gsgp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [gsgp_pkg::CSR_IDX_W-1:0]    index;
   logic [gsgp_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/gsgp_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module gsgp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hw/rtl/greedy_streaming_graph_partitioner.sv]
// Greedy streaming graph partitioner: edge requests add weights per partition, assign
// requests pick the best partition. Edges are taken one per cycle while idle (label RAM
// read). An assign steps through MUL_LO, MUL_HI and SCORE per partition in use, then waits
// in WRITE for a free result register, which takes its result as the request side is freed
// (two partial products and an add/compare per partition). Synchronous reset clears sizes
// and sums, then sweeps the label RAM with requests held off; uses gsgp_pkg/if/ram.
module greedy_streaming_graph_partitioner #(
   parameter int MAX_VERTICES = gsgp_pkg::MAX_VERTICES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gsgp_req_if.sink   req_ch,
   gsgp_rsp_if.source rsp_ch,
   gsgp_csr_if.sink   csr_ch
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int PW = gsgp_pkg::PART_W;
   localparam int NP = gsgp_pkg::MAX_PARTS;
   localparam int SW = gsgp_pkg::SUM_W;
   localparam int LW = gsgp_pkg::LABEL_W;
   localparam int ZW = gsgp_pkg::SIZE_W;

   localparam logic [AW-1:0] CLR_LAST = AW'(MAX_VERTICES - 1);
   localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic [ZW-1:0] SIZE_MAX = {ZW{1'b1}};

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MUL_LO = 3'd2;
   localparam logic [2:0] ST_MUL_HI = 3'd3;
   localparam logic [2:0] ST_SCORE  = 3'd4;
   localparam logic [2:0] ST_WRITE  = 3'd5;

   logic [2:0]                            state_ff, state_in;
   logic [AW-1:0]                         clr_addr_ff, clr_addr_in;
   logic [LW-1:0]                         num_parts_ff, num_parts_in;
   logic [gsgp_pkg::CAP_W-1:0]            capacity_ff, capacity_in;
   gsgp_pkg::sum_type                     edge_sum_ff [NP];
   gsgp_pkg::sum_type                     edge_sum_in [NP];
   gsgp_pkg::size_type                    part_size_ff [NP];
   gsgp_pkg::size_type                    part_size_in [NP];
   logic                                  edge_pend_ff, edge_pend_in;
   logic                                  edge_ok_ff, edge_ok_in;
   logic signed [gsgp_pkg::WEIGHT_W-1:0]  edge_w_ff, edge_w_in;
   logic [gsgp_pkg::VERTEX_W-1:0]         vid_ff, vid_in;
   logic                                  vid_ok_ff, vid_ok_in;
   logic [PW-1:0]                         last_idx_ff, last_idx_in;
   logic [PW-1:0]                         idx_ff, idx_in;
   logic signed [gsgp_pkg::LO_P_W-1:0]    lo_prod_ff, lo_prod_in;
   logic signed [gsgp_pkg::HI_P_W-1:0]    hi_prod_ff, hi_prod_in;
   logic signed [gsgp_pkg::SCORE_W-1:0]   best_score_ff, best_score_in;
   logic [PW-1:0]                         best_idx_ff, best_idx_in;
   logic [ZW-1:0]                         best_size_ff, best_size_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [gsgp_pkg::VERTEX_W-1:0]         rsp_vertex_ff, rsp_vertex_in;
   logic [LW-1:0]                         rsp_part_ff, rsp_part_in;
   logic [ZW-1:0]                         rsp_size_ff, rsp_size_in;

   logic                                  req_fire;
   logic                                  wr_fire;
   logic [31:0]                           dest_ext;
   logic [31:0]                           vid_ext;
   logic [AW-1:0]                         ram_raddr;
   logic [AW-1:0]                         ram_waddr;
   logic [LW-1:0]                         ram_wdata;
   logic                                  ram_we;
   logic [LW-1:0]                         ram_rdata;
   logic [LW-1:0]                         lab_m1;
   logic                                  lab_valid;
   logic [PW-1:0]                         rd_idx;
   gsgp_pkg::sum_type                     sel_sum;
   logic [ZW-1:0]                         sel_size;
   logic signed [SW:0]                    acc;
   gsgp_pkg::sum_type                     acc_sat;
   logic signed [gsgp_pkg::PEN_W-1:0]     pen;
   logic signed [gsgp_pkg::SUM_LO_W:0]    sum_lo;
   logic signed [gsgp_pkg::SUM_HI_W-1:0]  sum_hi;
   logic signed [gsgp_pkg::SCORE_W-1:0]   score;
   logic                                  take;
   logic [ZW-1:0]                         new_size;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign wr_fire  = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ch.ready);

   // Handshake outputs.
   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_vertex    = rsp_vertex_ff;
   assign rsp_ch.out_partition = rsp_part_ff;
   assign rsp_ch.out_size      = rsp_size_ff;

   // Label RAM addressing: sweep on clear, winner write on assign, lookup on edge.
   assign dest_ext  = 32'(req_ch.dest_vertex);
   assign vid_ext   = 32'(vid_ff);
   assign ram_raddr = dest_ext[AW-1:0];
   assign ram_we    = (state_ff == ST_CLEAR) || (wr_fire && vid_ok_ff);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : vid_ext[AW-1:0];
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : LW'({1'b0, best_idx_ff} + 1'b1);

   gsgp_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_VERTICES)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Label of the pending edge's destination, turned into a partition index.
   assign lab_m1    = ram_rdata - 1'b1;
   assign lab_valid = edge_ok_ff && (ram_rdata != '0) && (ram_rdata <= LW'(NP));

   // One read index into the sum and size arrays: edge label while idle, walk index otherwise.
   assign rd_idx   = (state_ff == ST_IDLE) ? lab_m1[PW-1:0] : idx_ff;
   assign sel_sum  = edge_sum_ff[rd_idx];
   assign sel_size = part_size_ff[rd_idx];

   // Saturating edge accumulation.
   always_comb begin
      acc     = (SW+1)'(sel_sum) + (SW+1)'(edge_w_ff);
      acc_sat = acc[SW-1:0];
      if (acc[SW] != acc[SW-1]) begin
         acc_sat = acc[SW] ? SUM_MIN : SUM_MAX;
      end
   end

   // Size penalty and the two halves of the sum for the partial products.
   assign pen    = $signed({1'b0, capacity_ff}) - $signed(gsgp_pkg::PEN_W'(sel_size));
   assign sum_lo = $signed({1'b0, sel_sum[gsgp_pkg::SUM_LO_W-1:0]});
   assign sum_hi = sel_sum[SW-1:gsgp_pkg::SUM_LO_W];

   // Exact score and the selection rule: higher score, then smaller size, then later index.
   assign score = (gsgp_pkg::SCORE_W'(hi_prod_ff) <<< gsgp_pkg::SUM_LO_W)
                  + gsgp_pkg::SCORE_W'(lo_prod_ff);
   assign take  = (idx_ff == '0) || (score > best_score_ff)
                  || ((score == best_score_ff) && (best_size_ff >= sel_size));

   assign new_size = (best_size_ff == SIZE_MAX) ? best_size_ff : best_size_ff + 1'b1;

   // Next-state logic.
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      num_parts_in  = num_parts_ff;
      capacity_in   = capacity_ff;
      edge_sum_in   = edge_sum_ff;
      part_size_in  = part_size_ff;
      edge_pend_in  = req_fire && (req_ch.kind == gsgp_pkg::KIND_EDGE);
      edge_ok_in    = dest_ext < 32'(MAX_VERTICES);
      edge_w_in     = req_ch.edge_weight;
      vid_in        = vid_ff;
      vid_ok_in     = vid_ok_ff;
      last_idx_in   = last_idx_ff;
      idx_in        = idx_ff;
      lo_prod_in    = lo_prod_ff;
      hi_prod_in    = hi_prod_ff;
      best_score_in = best_score_ff;
      best_idx_in   = best_idx_ff;
      best_size_in  = best_size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_part_in   = rsp_part_ff;
      rsp_size_in   = rsp_size_ff;

      // Register writes.
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            gsgp_pkg::CSR_NUM_PARTS: num_parts_in = csr_ch.data[LW-1:0];
            gsgp_pkg::CSR_CAPACITY:  capacity_in  = csr_ch.data;
            default: ;
         endcase
      end

      // The edge read last cycle lands in its partition sum.
      if (edge_pend_ff && lab_valid) begin
         edge_sum_in[rd_idx] = acc_sat;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_ch.kind == gsgp_pkg::KIND_ASSIGN)) begin
               vid_in    = req_ch.vertex_id;
               vid_ok_in = 32'(req_ch.vertex_id) < 32'(MAX_VERTICES);
               idx_in    = '0;
               if (num_parts_ff == '0) begin
                  last_idx_in = '0;
               end else if (num_parts_ff > LW'(NP)) begin
                  last_idx_in = PW'(NP - 1);
               end else begin
                  last_idx_in = PW'(num_parts_ff - 1'b1);
               end
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            lo_prod_in = sum_lo * pen;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            hi_prod_in = sum_hi * pen;
            state_in   = ST_SCORE;
         end
         ST_SCORE: begin
            if (take) begin
               best_score_in = score;
               best_idx_in   = idx_ff;
               best_size_in  = sel_size;
            end
            if (idx_ff == last_idx_ff) begin
               state_in = ST_WRITE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MUL_LO;
            end
         end
         ST_WRITE: begin
            // Commit the winner once the result register is free.
            if (wr_fire) begin
               part_size_in[best_idx_ff] = new_size;
               for (int p = 0; p < NP; p++) begin
                  edge_sum_in[p] = '0;
               end
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = vid_ff;
               rsp_part_in   = LW'({1'b0, best_idx_ff} + 1'b1);
               rsp_size_in   = new_size;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, configuration registers and partition state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         num_parts_ff <= gsgp_pkg::NUM_PARTS_RST;
         capacity_ff  <= gsgp_pkg::CAPACITY_RST;
         edge_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NP; p++) begin
            edge_sum_ff[p]  <= '0;
            part_size_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         num_parts_ff <= num_parts_in;
         capacity_ff  <= capacity_in;
         edge_pend_ff <= edge_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         edge_sum_ff  <= edge_sum_in;
         part_size_ff <= part_size_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      edge_ok_ff    <= edge_ok_in;
      edge_w_ff     <= edge_w_in;
      vid_ff        <= vid_in;
      vid_ok_ff     <= vid_ok_in;
      last_idx_ff   <= last_idx_in;
      idx_ff        <= idx_in;
      lo_prod_ff    <= lo_prod_in;
      hi_prod_ff    <= hi_prod_in;
      best_score_ff <= best_score_in;
      best_idx_ff   <= best_idx_in;
      best_size_ff  <= best_size_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_part_ff   <= rsp_part_in;
      rsp_size_ff   <= rsp_size_in;
   end

endmodule

[bench/gsgp_checker.sv]
// Scoreboard for the graph partitioner: watches request, result and register channels,
// predicts each assignment and compares it with the result seen on the result channel.
// Depends on gsgp_pkg and the channel interfaces in gsgp_if.
module gsgp_checker (
   input  logic clock,
   input  logic reset,
   gsgp_req_if  req_mon,
   gsgp_rsp_if  rsp_mon,
   gsgp_csr_if  csr_mon,
   output int   fail_count,
   output int   open_count,
   output int   checked_count
);
   import gsgp_pkg::*;

   localparam logic [SIZE_W-1:0] SIZE_CEIL = {SIZE_W{1'b1}};
   localparam longint SUM_CEIL  = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
   localparam longint SUM_FLOOR = -(64'sd1 <<< (SUM_W - 1));

   typedef struct {
      logic [VERTEX_W-1:0] vertex;
      logic [LABEL_W-1:0]  part;
      logic [SIZE_W-1:0]   size;
   } placement_t;

   // Mirror of the block's state and registers.
   logic [LABEL_W-1:0] label_mem [MAX_VERTICES_DEF];
   size_type           part_size [MAX_PARTS];
   sum_type            edge_sum  [MAX_PARTS];
   logic [LABEL_W-1:0] parts_reg;
   logic [CAP_W-1:0]   cap_reg;

   placement_t placement_q [$];
   int         errors;
   int         compared;

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   // An edge adds its weight to the sum of the destination's partition, saturating.
   function automatic void add_edge_weight(input logic [VERTEX_W-1:0] dst,
                                           input logic signed [WEIGHT_W-1:0] w);
      logic [LABEL_W-1:0] lab;
      longint             s;
      lab = label_mem[dst];
      if (lab != 0 && lab <= MAX_PARTS) begin
         s = longint'(edge_sum[lab - 1]) + longint'(w);
         if (s > SUM_CEIL) s = SUM_CEIL;
         if (s < SUM_FLOOR) s = SUM_FLOOR;
         edge_sum[lab - 1] = sum_type'(s);
      end
   endfunction

   // Scores every partition in use, picks the winner and updates the state.
   function automatic placement_t place_vertex(input logic [VERTEX_W-1:0] vid);
      placement_t          res;
      int                  parts;
      int                  best;
      longint              pen;
      logic signed [95:0]  lhs;
      logic signed [95:0]  rhs;
      logic signed [95:0]  score;
      logic signed [95:0]  best_score;
      parts = int'(parts_reg);
      if (parts == 0) parts = 1;
      if (parts > MAX_PARTS) parts = MAX_PARTS;
      best = 0;
      best_score = '0;
      for (int i = 0; i < parts; i++) begin
         pen = longint'(cap_reg) - longint'(part_size[i]);
         lhs = edge_sum[i];
         rhs = pen;
         score = lhs * rhs;
         if (i == 0 || score > best_score) begin
            best = i;
            best_score = score;
         end else if (score == best_score && part_size[best] >= part_size[i]) begin
            // Equal score: smaller size wins, the later partition on equal size.
            best = i;
         end
      end
      label_mem[vid] = LABEL_W'(best + 1);
      if (part_size[best] < SIZE_CEIL) part_size[best] = part_size[best] + 1'b1;
      for (int i = 0; i < MAX_PARTS; i++) edge_sum[i] = '0;
      res.vertex = vid;
      res.part   = LABEL_W'(best + 1);
      res.size   = part_size[best];
      return res;
   endfunction

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      placement_t head;
      if (reset) begin
         foreach (label_mem[v]) label_mem[v] = '0;
         foreach (part_size[p]) part_size[p] = '0;
         foreach (edge_sum[p]) edge_sum[p] = '0;
         parts_reg = NUM_PARTS_RST;
         cap_reg   = CAPACITY_RST;
         placement_q.delete();
      end else begin
         // Results are checked against the oldest pending assignment.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (placement_q.size() == 0) begin
               report_mismatch($sformatf("result for vertex %0d with no assignment pending",
                                         rsp_mon.out_vertex));
            end else begin
               head = placement_q.pop_front();
               compared++;
               if (rsp_mon.out_vertex !== head.vertex)
                  report_mismatch($sformatf("out_vertex got %0d expected %0d",
                                            rsp_mon.out_vertex, head.vertex));
               if (rsp_mon.out_partition !== head.part)
                  report_mismatch($sformatf("vertex %0d out_partition got %0d expected %0d",
                                            head.vertex, rsp_mon.out_partition, head.part));
               if (rsp_mon.out_size !== head.size)
                  report_mismatch($sformatf("vertex %0d out_size got %0d expected %0d",
                                            head.vertex, rsp_mon.out_size, head.size));
            end
         end
         // Register writes; unused indexes are ignored.
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_NUM_PARTS: parts_reg = csr_mon.data[LABEL_W-1:0];
               CSR_CAPACITY:  cap_reg   = csr_mon.data;
               default: ;
            endcase
         end
         // Accepted requests update the prediction.
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_EDGE)
               add_edge_weight(req_mon.dest_vertex, req_mon.edge_weight);
            else
               placement_q.push_back(place_vertex(req_mon.vertex_id));
         end
      end
      open_count    <= placement_q.size();
      fail_count    <= errors;
      checked_count <= compared;
   end

   initial begin
      errors        = 0;
      compared      = 0;
      open_count    = 0;
      fail_count    = 0;
      checked_count = 0;
      parts_reg     = NUM_PARTS_RST;
      cap_reg       = CAPACITY_RST;
   end

endmodule

[bench/tb.sv]
// Top of the partitioner testbench: clock, reset, stimulus, random stalls and verdict.
// Depends on gsgp_pkg, gsgp_if, the partitioner top level and gsgp_checker.
module tb;
   import gsgp_pkg::*;

   localparam int IDLE_WAIT      = 3 * MAX_PARTS + 2 + 10;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic idle_on;

   int fail_count;
   int open_count;
   int checked_count;
   int edges_sent;
   int assigns_sent;
   int writes_done;
   int seen_ids [$];

   gsgp_req_if req_ch ();
   gsgp_rsp_if rsp_ch ();
   gsgp_csr_if csr_ch ();

   greedy_streaming_graph_partitioner i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   gsgp_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .checked_count (checked_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gap length: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Weight: extremes, full random or small signed values.
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h7FFF_FFFF;
      if (r == 1) return 32'h8000_0000;
      if (r < 5) return $urandom();
      return WEIGHT_W'($urandom_range(0, 200) - 100);
   endfunction

   // Waits until no assignment is outstanding.
   task automatic wait_drained();
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // Sends one request and waits for it to be taken, then idles for a random gap.
   task automatic send_request(input logic kind, input logic [VERTEX_W-1:0] vid,
                               input logic [VERTEX_W-1:0] dst,
                               input logic [WEIGHT_W-1:0] w);
      int gap;
      req_ch.kind        <= kind;
      req_ch.vertex_id   <= vid;
      req_ch.dest_vertex <= dst;
      req_ch.edge_weight <= w;
      req_ch.valid       <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      if (kind == KIND_EDGE) edges_sent++;
      else assigns_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic add_edge(input logic [VERTEX_W-1:0] dst, input logic [WEIGHT_W-1:0] w);
      send_request(KIND_EDGE, VERTEX_W'($urandom()), dst, w);
   endtask

   task automatic assign_vertex(input logic [VERTEX_W-1:0] vid);
      send_request(KIND_ASSIGN, vid, VERTEX_W'($urandom()), WEIGHT_W'($urandom()));
      seen_ids.push_back(int'(vid));
      if (seen_ids.size() > 200) void'(seen_ids.pop_front());
   endtask

   // Register write, only once the block has gone quiet.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (IDLE_WAIT) @(posedge clock);
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      writes_done++;
   endtask

   // The partition count carries random upper bits that the block must drop.
   task automatic set_config(input int np, input logic [CAP_W-1:0] cap);
      write_reg(CSR_NUM_PARTS, ($urandom() & 32'hFFFF_FFE0) | CSR_DATA_W'(np));
      write_reg(CSR_CAPACITY, cap);
   endtask

   // Extremes, ties, unassigned and stale labels, reassignment and odd registers.
   task automatic directed_checks();
      idle_on = 1'b0;
      assign_vertex(16'd0);
      assign_vertex(16'hFFFF);
      add_edge(16'd0, 32'h7FFF_FFFF);
      add_edge(16'hFFFF, 32'h8000_0000);
      add_edge(16'd12345, 32'd5);
      assign_vertex(16'd1);
      add_edge(16'd1, 32'hFFFF_FFFF);
      assign_vertex(16'd0);
      // Capacity below the sizes makes the penalty negative.
      set_config(16, 32'd1);
      add_edge(16'd0, 32'd1000);
      add_edge(16'd1, 32'd1000);
      assign_vertex(16'd2);
      assign_vertex(16'd3);
      assign_vertex(16'd4);
      // A zero partition count behaves as one partition.
      set_config(0, 32'd4096);
      add_edge(16'd2, 32'd7);
      assign_vertex(16'd5);
      // A count above the maximum is clamped.
      set_config(31, 32'hFFFF_FFFF);
      add_edge(16'd3, 32'hFFFF_FFCE);
      add_edge(16'd4, 32'd60);
      assign_vertex(16'd6);
      // Labels above the current count still accumulate but are not scored.
      set_config(2, 32'd4096);
      add_edge(16'd3, 32'd100000);
      add_edge(16'd4, 32'hFFFF_FFFD);
      assign_vertex(16'd7);
      write_reg(CSR_SPARE, $urandom());
   endtask

   // Random vertices with random out-edges, some stray edges, some drains.
   task automatic random_phase(input int np, input logic [CAP_W-1:0] cap, input int n_items);
      int sent;
      int n_edges;
      int r;
      logic [VERTEX_W-1:0] dst;
      logic [VERTEX_W-1:0] vid;
      set_config(np, cap);
      sent = 0;
      while (sent < n_items) begin
         idle_on = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 9);
         n_edges = (r == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
         for (int e = 0; e < n_edges; e++) begin
            if (seen_ids.size() > 0 && $urandom_range(0, 4) != 0)
               dst = VERTEX_W'(seen_ids[$urandom_range(0, seen_ids.size() - 1)]);
            else
               dst = VERTEX_W'($urandom());
            add_edge(dst, pick_weight());
            sent++;
         end
         // Now and then the edges are left to run into the next vertex.
         if (r != 1) begin
            vid = ($urandom_range(0, 9) < 8) ? VERTEX_W'($urandom_range(0, 2047))
                                             : VERTEX_W'($urandom());
            assign_vertex(vid);
            sent++;
            if ($urandom_range(0, 19) == 0) begin
               req_ch.valid <= 1'b0;
               wait_drained();
            end
         end
      end
   endtask

   // Result side: random stalls, with stretches of none while idling is off.
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            hold = pick_gap();
            rsp_ch.ready <= (hold == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet);
            $display("greedy_streaming_graph_partitioner test failed");
            $finish;
         end
      end
   end

   // Main stimulus and verdict.
   initial begin
      edges_sent   = 0;
      assigns_sent = 0;
      writes_done  = 0;
      idle_on      = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_EDGE;
      req_ch.vertex_id   <= '0;
      req_ch.dest_vertex <= '0;
      req_ch.edge_weight <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_NUM_PARTS;
      csr_ch.data        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      directed_checks();
      random_phase(16, 32'd4096, 125);
      random_phase(1, 32'hFFFF_FFFF, 125);
      random_phase($urandom_range(3, 15), $urandom_range(1, 64), 125);
      random_phase(0, $urandom(), 125);
      random_phase(31, 32'd1, 125);
      random_phase(2, 32'd4096, 125);

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (IDLE_WAIT) @(posedge clock);

      $display("covered %0d edge and %0d assign requests, %0d register writes",
               edges_sent, assigns_sent, writes_done);
      $display("%0d results checked; partition counts 0 to 31, capacity 1 to 2^32-1",
               checked_count);
      if (fail_count == 0 && open_count == 0) begin
         $display("greedy_streaming_graph_partitioner test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, open_count);
         $display("greedy_streaming_graph_partitioner test failed");
      end
      $finish;
   end

endmodule
